/* rtl/indexed_list_engine_macros.svh */
// Assertion macros used by the list engine top level.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ILE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/ile_pkg.sv */
// Types and constants of the indexed list engine.
`default_nettype none

package ile_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 8;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  // Wide enough for any cell position up to the largest supported depth.
  localparam int POS_W    = 12;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 3'd0,
    CMD_DROP   = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_READ   = 3'd4,
    CMD_CLEAR  = 3'd5,
    CMD_WRITE  = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_ERASE,
    OP_WRITE,
    OP_TAP_LOAD,
    OP_TAP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                op;
    logic [POS_W-1:0]        pos;
    logic signed [VAL_W-1:0] value;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

endpackage

`default_nettype wire

/* rtl/ile_ifs.sv */
// Handshake interfaces for the command and result channels.
`default_nettype none

interface ile_req_if;
  import ile_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic [IDX_W-1:0]        index;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, cmd, index, value, input ready);
  modport sink   (input valid, cmd, index, value, output ready);
endinterface

interface ile_rsp_if;
  import ile_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [VAL_W-1:0] read_value;
  logic [COUNT_W-1:0]      count;
  logic                    is_empty;
  logic [STATUS_W-1:0]     status;

  modport source (output valid, read_value, count, is_empty, status, input ready);
  modport sink   (input valid, read_value, count, is_empty, status, output ready);
endinterface

`default_nettype wire

/* rtl/ile_cell.sv */
// One storage cell of the list: holds a word and a read tap.
`default_nettype none

module ile_cell #(
  parameter logic [ile_pkg::POS_W-1:0] POS = '0
) (
  input  logic                            clk,
  input  ile_pkg::cell_ctrl_t             ctrl,
  input  logic signed [ile_pkg::VAL_W-1:0] left,
  input  logic signed [ile_pkg::VAL_W-1:0] right,
  input  logic signed [ile_pkg::VAL_W-1:0] right_tap,
  output logic signed [ile_pkg::VAL_W-1:0] word,
  output logic signed [ile_pkg::VAL_W-1:0] tap
);
  import ile_pkg::*;

  // Insert moves every word from the position onward one cell up; erase pulls
  // every word above the position one cell down.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (ctrl.pos == POS) begin
          word <= ctrl.value;
        end else if (ctrl.pos < POS) begin
          word <= left;
        end
      end
      OP_ERASE: begin
        if (ctrl.pos <= POS) begin
          word <= right;
        end
      end
      OP_WRITE: begin
        if (ctrl.pos == POS) begin
          word <= ctrl.value;
        end
      end
      OP_TAP_LOAD:  tap <= word;
      OP_TAP_SHIFT: tap <= right_tap;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/ile_row.sv */
// Row of list cells linked to their neighbors, with the read tap at cell zero.
`default_nettype none

module ile_row #(
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  ile_pkg::cell_ctrl_t              ctrl,
  output logic signed [ile_pkg::VAL_W-1:0] head_tap
);
  import ile_pkg::*;

  logic signed [VAL_W-1:0] words [DEPTH];
  logic signed [VAL_W-1:0] taps  [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VAL_W-1:0] left;
    logic signed [VAL_W-1:0] right;
    logic signed [VAL_W-1:0] right_tap;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid_l
      assign left = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right     = '0;
      assign right_tap = '0;
    end else begin : g_mid_r
      assign right     = words[i+1];
      assign right_tap = taps[i+1];
    end

    ile_cell #(
      .POS(POS_W'(i))
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .left      (left),
      .right     (right),
      .right_tap (right_tap),
      .word      (words[i]),
      .tap       (taps[i])
    );
  end

  assign head_tap = taps[0];

endmodule

`default_nettype wire

/* rtl/indexed_list_engine.sv */
// Top level of the indexed list engine: command decode, fill count and result register.
//
// A fixed-capacity ordered list of signed 32-bit words held in a row of DEPTH
// cells. Commands arrive as beats on req (cmd, index, value); each command
// gives exactly one result beat on rsp (read_value, count, is_empty, status).
// Append, drop, insert, erase, write and clear act on all cells at once in the
// cycle the beat is accepted; the result is valid the next cycle, so these
// commands sustain one beat per cycle while the receiver keeps up.
// A read loads every cell's word into its tap and then shifts the taps toward
// cell zero one cell per cycle, so a read at index k gives its result once its
// word reaches cell zero, and the next command is taken after that.
// A refused command (full list or bad index) leaves the list untouched.
// The result register holds a beat until rsp.ready; a new command is accepted
// in the same cycle the waiting result is taken, never while it is stalled.
// Reset empties the list and drops any pending result, and no command is taken
// while it is held; cell contents are not cleared, since a word is only read
// after it was written.
`default_nettype none

module indexed_list_engine #(
  parameter int DEPTH = 256
) (
  input logic        clk,
  input logic        rst,
  ile_req_if.sink    req,
  ile_rsp_if.source  rsp
);
  import ile_pkg::*;

  `include "indexed_list_engine_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  state_t                   state, state_next;
  logic [CW-1:0]            fill, fill_next;
  logic [AW-1:0]            walk, walk_next;
  cell_ctrl_t               ctrl;
  logic signed [VAL_W-1:0]  head_tap;

  logic                     out_valid;
  logic signed [VAL_W-1:0]  out_read_value;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_empty;
  status_t                  out_status;

  logic                     accept;
  logic                     full;
  logic [XW-1:0]            idx_x;
  logic [XW-1:0]            cnt_x;
  logic                     res_load;
  logic signed [VAL_W-1:0]  res_rd;
  status_t                  res_status;

  assign idx_x  = XW'(req.index);
  assign cnt_x  = XW'(fill);
  assign full   = (fill == CW'(DEPTH));
  assign accept = req.valid && req.ready;

  ile_row #(
    .DEPTH(DEPTH)
  ) u_row (
    .clk      (clk),
    .ctrl     (ctrl),
    .head_tap (head_tap)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    walk <= walk_next;
    if (res_load) begin
      out_read_value <= res_rd;
      out_count      <= COUNT_W'(fill_next);
      out_empty      <= (fill_next == '0);
      out_status     <= res_status;
    end
  end

  always_comb begin
    state_next = state;
    fill_next  = fill;
    walk_next  = walk;
    ctrl.op    = OP_NONE;
    ctrl.pos   = '0;
    ctrl.value = req.value;
    res_load   = 1'b0;
    res_rd     = '0;
    res_status = ST_OK;
    req.ready  = !rst && (state == S_IDLE) && (!out_valid || rsp.ready);

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_load = 1'b1;
          unique case (cmd_t'(req.cmd))
            CMD_APPEND: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.op   = OP_INSERT;
                ctrl.pos  = POS_W'(fill);
                fill_next = fill + 1'b1;
              end
            end
            CMD_DROP: begin
              if (fill != '0) begin
                fill_next = fill - 1'b1;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                res_status = ST_FULL;
              end else if (idx_x > cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.op   = OP_INSERT;
                ctrl.pos  = POS_W'(req.index);
                fill_next = fill + 1'b1;
              end
            end
            CMD_ERASE: begin
              if (idx_x >= cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.op   = OP_ERASE;
                ctrl.pos  = POS_W'(req.index);
                fill_next = fill - 1'b1;
              end
            end
            CMD_READ: begin
              if (idx_x >= cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                // The result comes once the word has walked down to cell zero.
                res_load   = 1'b0;
                ctrl.op    = OP_TAP_LOAD;
                walk_next  = AW'(req.index);
                state_next = S_WALK;
              end
            end
            CMD_CLEAR: begin
              fill_next = '0;
            end
            CMD_WRITE: begin
              if (idx_x >= cnt_x) begin
                res_status = ST_RANGE;
              end else begin
                ctrl.op  = OP_WRITE;
                ctrl.pos = POS_W'(req.index);
              end
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        if (walk == '0) begin
          res_load   = 1'b1;
          res_rd     = head_tap;
          state_next = S_IDLE;
        end else begin
          ctrl.op   = OP_TAP_SHIFT;
          walk_next = walk - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = out_read_value;
  assign rsp.count      = out_count;
  assign rsp.is_empty   = out_empty;
  assign rsp.status     = out_status;

  `ILE_ASSERT_SAME(a_fill_bound, 1'b1, fill <= CW'(DEPTH), "fill count exceeds capacity")
  `ILE_ASSERT_SAME(a_walk_blocks, state == S_WALK, !req.ready && !out_valid,
                   "command taken or result pending during a read walk")
  `ILE_ASSERT_NEXT(a_direct_result, accept && (req.cmd != CMD_READ), out_valid,
                   "non-read command gave no result beat")
  `ILE_ASSERT_NEXT(a_read_range, accept && (req.cmd == CMD_READ) && (idx_x >= cnt_x),
                   out_valid && (out_status == ST_RANGE),
                   "out-of-range read not refused at once")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Testbench for the indexed list engine: random and directed list commands checked by a scoreboard.
`timescale 1ns / 1ps

module testbench;
  import ile_pkg::*;

  localparam int LIST_DEPTH = 256;
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
  localparam logic signed [VAL_W-1:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [VAL_W-1:0] read_value;
    logic [COUNT_W-1:0]      count;
    logic                    is_empty;
    logic [STATUS_W-1:0]     status;
  } list_result_t;

  // Tracks the list contents and the queue of results still owed by the block.
  class list_scoreboard;
    logic signed [VAL_W-1:0] words [LIST_DEPTH];
    int unsigned             fill;
    list_result_t            owed [$];
    int                      errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int outstanding();
      return owed.size();
    endfunction

    function void note_command(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                               logic signed [VAL_W-1:0] val);
      list_result_t r;
      int unsigned  k;
      r.read_value = '0;
      r.status     = ST_OK;
      case (c)
        CMD_APPEND: begin
          if (fill >= LIST_DEPTH) r.status = ST_FULL;
          else begin
            words[fill] = val;
            fill++;
          end
        end
        CMD_DROP: begin
          if (fill > 0) fill--;
        end
        CMD_INSERT: begin
          if (fill >= LIST_DEPTH) r.status = ST_FULL;
          else if (idx > fill) r.status = ST_RANGE;
          else begin
            for (k = fill; k > idx; k--) words[k] = words[k-1];
            words[idx] = val;
            fill++;
          end
        end
        CMD_ERASE: begin
          if (idx >= fill) r.status = ST_RANGE;
          else begin
            for (k = idx; k + 1 < fill; k++) words[k] = words[k+1];
            fill--;
          end
        end
        CMD_READ: begin
          if (idx >= fill) r.status = ST_RANGE;
          else r.read_value = words[idx];
        end
        CMD_CLEAR: fill = 0;
        CMD_WRITE: begin
          if (idx >= fill) r.status = ST_RANGE;
          else words[idx] = val;
        end
        default: ;
      endcase
      r.count    = fill[COUNT_W-1:0];
      r.is_empty = (fill == 0);
      owed = {owed, r};
    endfunction

    function void report_field(string field, longint exp_v, longint act_v);
      errors++;
      if (errors <= 50)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
    endfunction

    function void check_result(logic signed [VAL_W-1:0] rv, logic [COUNT_W-1:0] cnt,
                               logic emp, logic [STATUS_W-1:0] st);
      list_result_t e;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= 50)
          $display("%0t: result beat with nothing expected, count %0d status %0d",
                   $time, cnt, st);
        return;
      end
      e = owed.pop_front();
      if (rv !== e.read_value) report_field("read_value", e.read_value, rv);
      if (cnt !== e.count) report_field("count", e.count, cnt);
      if (emp !== e.is_empty) report_field("is_empty", e.is_empty, emp);
      if (st !== e.status) report_field("status", e.status, st);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  ile_req_if req ();
  ile_rsp_if rsp ();

  indexed_list_engine #(.DEPTH(LIST_DEPTH)) u_dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  list_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_requests = 0;

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.read_value, rsp.count, rsp.is_empty, rsp.status);
  end

  task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] idx,
                          input logic signed [VAL_W-1:0] val);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.cmd   <= c;
    req.index <= idx;
    req.value <= val;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    sb.note_command(c, idx, val);
  endtask

  task automatic wait_for_results();
    req.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  function automatic logic signed [VAL_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return WORD_MIN;
      1: return WORD_MAX;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] pick_index(logic [CMD_W-1:0] c);
    int unsigned limit;
    int unsigned r;
    // Highest valid index is the count for insert, one below it otherwise.
    limit = (c == CMD_INSERT) ? sb.fill : sb.fill - 1;
    r = $urandom_range(99);
    if (r < 15) return IDX_W'($urandom_range(255));
    if (r < 27 || (c != CMD_INSERT && sb.fill == 0))
      return (limit + 1 > 255) ? 8'd255 : IDX_W'(limit + 1);
    if (limit > 255) limit = 255;
    return IDX_W'($urandom_range(limit, 0));
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd();
    int unsigned r;
    logic [CMD_W-1:0] c;
    r = $urandom_range(99);
    if (r < 20) c = CMD_APPEND;
    else if (r < 35) c = CMD_INSERT;
    else if (r < 50) c = CMD_ERASE;
    else if (r < 58) c = CMD_DROP;
    else if (r < 82) c = CMD_READ;
    else if (r < 94) c = CMD_WRITE;
    else if (r < 97) c = CMD_CLEAR;
    else c = CMD_UNUSED;
    // Keep the list short so reads stay quick, and rarely let it run dry.
    if (sb.fill >= 32 && (c == CMD_APPEND || c == CMD_INSERT)) c = CMD_ERASE;
    if (sb.fill < 3 && (c == CMD_ERASE || c == CMD_DROP) && $urandom_range(1) == 1)
      c = CMD_APPEND;
    return c;
  endfunction

  task automatic run_random(input int n);
    logic [CMD_W-1:0] c;
    repeat (n) begin
      c = pick_cmd();
      send_cmd(c, pick_index(c), pick_word());
    end
  endtask

  // Fills the list to capacity, then exercises the full and top-index cases.
  task automatic fill_and_probe();
    send_cmd(CMD_CLEAR, IDX_W'($urandom), $urandom);
    while (sb.fill < LIST_DEPTH) begin
      if ($urandom_range(3) == 0)
        send_cmd(CMD_INSERT, IDX_W'($urandom_range(sb.fill, 0)), pick_word());
      else
        send_cmd(CMD_APPEND, IDX_W'($urandom), pick_word());
    end
    send_cmd(CMD_APPEND, 8'd0, pick_word());
    send_cmd(CMD_INSERT, 8'd0, pick_word());
    send_cmd(CMD_INSERT, 8'd255, pick_word());
    send_cmd(CMD_READ, 8'd255, '0);
    send_cmd(CMD_READ, 8'd0, '0);
    send_cmd(CMD_WRITE, 8'd255, WORD_MIN);
    send_cmd(CMD_READ, 8'd255, '0);
    send_cmd(CMD_ERASE, 8'd255, '0);
    send_cmd(CMD_INSERT, 8'd255, WORD_MAX);
    send_cmd(CMD_ERASE, 8'd0, '0);
    send_cmd(CMD_READ, 8'd255, '0);
    send_cmd(CMD_READ, 8'd254, '0);
    send_cmd(CMD_DROP, 8'd0, '0);
    send_cmd(CMD_CLEAR, 8'd0, '0);
  endtask

  initial begin
    req.valid <= 1'b0;
    req.cmd   <= CMD_APPEND;
    req.index <= '0;
    req.value <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty-list refusals and no-ops first, then a short list built at the edges.
    send_cmd(CMD_READ, 8'd0, '0);
    send_cmd(CMD_DROP, 8'd0, '0);
    send_cmd(CMD_ERASE, 8'd0, '0);
    send_cmd(CMD_WRITE, 8'd0, 32'sd5);
    send_cmd(CMD_INSERT, 8'd1, 32'sd9);
    send_cmd(CMD_UNUSED, 8'd255, -32'sd1);
    send_cmd(CMD_INSERT, 8'd0, WORD_MAX);
    send_cmd(CMD_APPEND, 8'd255, WORD_MIN);
    send_cmd(CMD_APPEND, 8'd0, 32'sd0);
    send_cmd(CMD_APPEND, 8'd0, -32'sd1);
    send_cmd(CMD_INSERT, 8'd4, 32'sh5555_5555);
    send_cmd(CMD_INSERT, 8'd2, 32'shAAAA_AAAA);
    send_cmd(CMD_READ, 8'd0, '0);
    send_cmd(CMD_READ, 8'd5, '0);
    send_cmd(CMD_READ, 8'd2, '0);
    send_cmd(CMD_WRITE, 8'd5, 32'sd1);
    send_cmd(CMD_READ, 8'd5, '0);
    send_cmd(CMD_ERASE, 8'd0, '0);
    send_cmd(CMD_ERASE, 8'd4, '0);
    send_cmd(CMD_ERASE, 8'd4, '0);
    send_cmd(CMD_READ, 8'd255, '0);
    send_cmd(CMD_DROP, 8'd0, '0);
    send_cmd(CMD_CLEAR, 8'd0, '0);
    send_cmd(CMD_READ, 8'd0, '0);
    wait_for_results();

    tx_idle_pct = 10;
    rx_idle_pct = 76;
    run_random(230);
    wait_for_results();

    tx_idle_pct = 76;
    rx_idle_pct = 10;
    run_random(220);
    wait_for_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // The receiver stalls for a long stretch while commands keep coming.
    hold_requests++;
    run_random(60);
    wait_for_results();
    fill_and_probe();
    wait_for_results();
    run_random(150);
    wait_for_results();
    repeat (300) @(posedge clk);

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("indexed_list_engine verification clean");
    end else begin
      $display("indexed_list_engine verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("indexed_list_engine verification failed");
    $finish;
  end

endmodule
